// ----- rtl/css_pkg.sv -----
package css_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int CFG_W          = 32;
  localparam int IDX_W          = 2;
  localparam int CT_W           = 3;
  localparam int HIST_DEPTH     = 13;
  localparam int HEAD_DEPTH     = 16;
  localparam int HEAD_AW        = $clog2(HEAD_DEPTH);
  localparam int SIG_COUNT      = 12;
  localparam int SIG_MAX        = 14;
  localparam int RISK_W         = 4;

  localparam logic [CFG_W-1:0] SIZE_LIMIT_RST = 32'd52428800;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CONTENT_TYPE = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_LIMIT   = 2'd1;

  // content type codes
  localparam logic [CT_W-1:0] CT_NONE = 3'd0;
  localparam logic [CT_W-1:0] CT_JPEG = 3'd1;
  localparam logic [CT_W-1:0] CT_PNG  = 3'd2;
  localparam logic [CT_W-1:0] CT_WEBP = 3'd3;
  localparam logic [CT_W-1:0] CT_HEIF = 3'd4;

  // signatures right-aligned: the byte that ends a match sits in bits [7:0]
  localparam logic [SIG_MAX*8-1:0] SIG_TEXT [SIG_COUNT] = '{
    "\\x00",
    "\\x0a",
    "\\x0d",
    "<script",
    "</script>",
    "javascript:",
    "vbscript:",
    "data:text/html",
    "<?php",
    "<?=",
    "<!--#",
    "\\xff\\xd8\\xff"
  };

  localparam int SIG_LEN [SIG_COUNT] = '{4, 4, 4, 7, 9, 11, 9, 14, 5, 3, 5, 12};

  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TXT_RIFF  = "RIFF";
  localparam logic [31:0] TXT_WEBP  = "WEBP";
  localparam logic [31:0] TXT_FTYP  = "ftyp";
  localparam logic [31:0] TXT_HEIC  = "heic";
  localparam logic [31:0] TXT_HEIX  = "heix";
  localparam logic [31:0] TXT_HEVC  = "hevc";
  localparam logic [31:0] TXT_HEVX  = "hevx";
  localparam logic [31:0] TXT_MIF1  = "mif1";

  localparam logic [7:0] JPEG_SOI0  = 8'hFF;
  localparam logic [7:0] JPEG_SOI1  = 8'hD8;
  localparam logic [7:0] JPEG_EOI0  = 8'hFF;
  localparam logic [7:0] JPEG_EOI1  = 8'hD9;

  localparam int RISK_MATCH  = 8;
  localparam int RISK_FORMAT = 6;
  localparam int RISK_SIZE   = 2;
  localparam int RISK_CAP    = 10;

endpackage

// ----- rtl/css_cell.sv -----
module css_cell #(
  parameter int POS = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift_en,
  input  logic                         clear,
  input  logic [7:0]                   byte_in,
  output logic [7:0]                   byte_out,
  output logic [css_pkg::SIG_COUNT-1:0] hit
);
  import css_pkg::*;

  // this cell holds the byte that lies POS+1 places before the current one
  localparam int OFS = POS + 1;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_out <= '0;
    end else if (shift_en) begin
      byte_out <= byte_in;
    end
  end

  // positions beyond a signature's length do not care
  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      if (OFS >= SIG_LEN[s]) begin
        hit[s] = 1'b1;
      end else begin
        hit[s] = (byte_out == SIG_TEXT[s][8*OFS +: 8]);
      end
    end
  end

endmodule

// ----- rtl/content_signature_scanner.sv -----
// Content signature scanner. Takes a buffer one byte per request on the s_ side,
// s_tlast marking its final byte, and returns one 8-bit verdict on the m_ side for
// each buffer, in the cycle after its last byte. A new byte is taken every cycle: a
// row of thirteen history cells shifts the recent bytes along and compares each
// against its column of the twelve text signatures, and a verdict waiting in the
// output register only stalls the input once a second verdict would follow it.
// The format register selects a JPEG, PNG, WebP or HEIF magic check on the first
// sixteen bytes (JPEG also checks the FF D9 trailer); size_limit sets the byte
// count above which size_warning is raised. Write the configuration only while no
// buffer is in progress.
module content_signature_scanner #(
  parameter int COUNT_BITS = css_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // data_byte
  input  logic                       s_tlast,   // last_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // is_safe, pattern_found, format_bad, size_warning, risk_tenths[3:0]
  output logic [7:0]                 m_tdata,
  input  logic                       cfg_we,
  input  logic [css_pkg::IDX_W-1:0]  cfg_index,
  input  logic [css_pkg::CFG_W-1:0]  cfg_data
);
  import css_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [CT_W-1:0]       fmt_sel;
  logic [CFG_W-1:0]      size_limit;
  logic [COUNT_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0] count_next;
  logic                  match_seen;
  logic [7:0]            head [HEAD_DEPTH];
  logic [7:0]            head_view [HEAD_DEPTH];
  logic [31:0]           head_word [HEAD_DEPTH/4];

  logic [7:0]            hist [HIST_DEPTH];
  logic [SIG_COUNT-1:0]  cell_hit [HIST_DEPTH];
  logic [SIG_COUNT-1:0]  sig_hit;

  logic                  accept;
  logic                  shift_en;
  logic                  clear;
  logic                  head_wr;
  logic [HEAD_AW-1:0]    head_idx;
  logic                  pf;
  logic                  fmt_ok;
  logic                  sw;
  logic [RISK_W:0]       risk_sum;
  logic [RISK_W-1:0]     risk;

  // only a last byte needs room in the output register
  assign s_tready = !m_tvalid || m_tready || !s_tlast;
  assign accept   = s_tvalid && s_tready;
  assign shift_en = accept && !s_tlast;
  assign clear    = accept && s_tlast;

  genvar k;
  generate
    for (k = 0; k < HIST_DEPTH; k++) begin : g_cell
      css_cell #(.POS(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .clear    (clear),
        .byte_in  ((k == 0) ? s_tdata : hist[(k == 0) ? 0 : k-1]),
        .byte_out (hist[k]),
        .hit      (cell_hit[k])
      );
    end
  endgenerate

  assign count_next = (&bytes_seen) ? bytes_seen : bytes_seen + 1'b1;
  assign head_wr    = (bytes_seen < COUNT_BITS'(HEAD_DEPTH));
  assign head_idx   = bytes_seen[HEAD_AW-1:0];

  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      sig_hit[s] = (s_tdata == SIG_TEXT[s][7:0])
                && (bytes_seen >= COUNT_BITS'(SIG_LEN[s] - 1));
      for (int c = 0; c < HIST_DEPTH; c++) begin
        sig_hit[s] = sig_hit[s] && cell_hit[c][s];
      end
    end
  end

  // head as it stands once the current byte is written
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_view[i] = (head_wr && head_idx == HEAD_AW'(i)) ? s_tdata : head[i];
    end
    for (int w = 0; w < HEAD_DEPTH/4; w++) begin
      head_word[w] = {head_view[4*w], head_view[4*w+1], head_view[4*w+2], head_view[4*w+3]};
    end
  end

  always_comb begin
    case (fmt_sel)
      CT_JPEG: begin
        fmt_ok = (count_next >= COUNT_BITS'(4))
              && head_view[0] == JPEG_SOI0 && head_view[1] == JPEG_SOI1
              && head_view[2] == JPEG_SOI0
              && hist[0] == JPEG_EOI0 && s_tdata == JPEG_EOI1;
      end
      CT_PNG: begin
        fmt_ok = (count_next >= COUNT_BITS'(8)) && {head_word[0], head_word[1]} == PNG_MAGIC;
      end
      CT_WEBP: begin
        fmt_ok = (count_next >= COUNT_BITS'(12))
              && head_word[0] == TXT_RIFF && head_word[2] == TXT_WEBP;
      end
      CT_HEIF: begin
        fmt_ok = (count_next >= COUNT_BITS'(16)) && head_word[1] == TXT_FTYP
              && (head_word[2] == TXT_HEIC || head_word[2] == TXT_HEIX
               || head_word[2] == TXT_HEVC || head_word[2] == TXT_HEVX
               || head_word[2] == TXT_MIF1);
      end
      default: begin
        fmt_ok = 1'b1;
      end
    endcase
  end

  assign pf = match_seen || (|sig_hit);
  assign sw = CMP_W'(count_next) > CMP_W'(size_limit);

  assign risk_sum = (pf      ? (RISK_W+1)'(RISK_MATCH)  : '0)
                  + (!fmt_ok ? (RISK_W+1)'(RISK_FORMAT) : '0)
                  + (sw      ? (RISK_W+1)'(RISK_SIZE)   : '0);
  assign risk = (risk_sum > (RISK_W+1)'(RISK_CAP)) ? RISK_W'(RISK_CAP) : risk_sum[RISK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_sel    <= CT_NONE;
      size_limit <= SIZE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONTENT_TYPE: fmt_sel    <= cfg_data[CT_W-1:0];
        REG_SIZE_LIMIT:   size_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
    end else if (clear) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
    end else if (accept) begin
      bytes_seen <= count_next;
      match_seen <= pf;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && head_wr) begin
      head[head_idx] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      m_tdata <= {risk, sw, !fmt_ok, pf, !pf && fmt_ok};
    end
  end

endmodule

// ----- rtl/css_checker.sv -----
module css_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("verdict changed while stalled");

  // the last byte of a buffer yields a verdict next cycle
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no verdict after last byte");

  a_safe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0] == !(m_tdata[1] || m_tdata[2]))
    else $error("is_safe disagrees with flags");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] <= 4'd10)
    else $error("risk above cap");

  a_match_risk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[7:4] >= 4'd8)
    else $error("match without match weight");

endmodule

bind content_signature_scanner css_checker u_css_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/scan_checker.sv -----
`timescale 1ns / 1ps
module scan_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      s_tlast,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [7:0]                m_tdata,
  input  logic                      cfg_we,
  input  logic [css_pkg::IDX_W-1:0] cfg_index,
  input  logic [css_pkg::CFG_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);
  import css_pkg::*;

  localparam int W_MATCH = 8;
  localparam int W_FORMAT = 6;
  localparam int W_SIZE = 2;
  localparam int W_CAP = 10;
  localparam int N_SIGS = 12;
  localparam logic [63:0] PNG_SIG = 64'h89504E470D0A1A0A;
  localparam logic [31:0] LIMIT_AT_RESET = 32'd52428800;

  // m_tdata from bit 0 up: is_safe, pattern_found, format_bad, size_warning, risk_tenths
  typedef struct packed {
    logic [3:0] risk;
    logic       size_warn;
    logic       fmt_bad;
    logic       found;
    logic       safe;
  } verdict_t;

  logic [7:0]  hist [13];
  logic [7:0]  head [16];
  logic [31:0] seen;
  logic        hit_flag;
  logic [2:0]  ctype;
  logic [31:0] limit;
  verdict_t    verdict_q [$];

  function automatic string sig_text(int k);
    case (k)
      0:  return "\\x00";
      1:  return "\\x0a";
      2:  return "\\x0d";
      3:  return "<script";
      4:  return "</script>";
      5:  return "javascript:";
      6:  return "vbscript:";
      7:  return "data:text/html";
      8:  return "<?php";
      9:  return "<?=";
      10: return "<!--#";
      default: return "\\xff\\xd8\\xff";
    endcase
  endfunction

  // signature whose final character is the current byte, earlier ones in the history
  function automatic logic sig_ends_here(int k, logic [7:0] cur, logic [31:0] cnt);
    string s;
    int n;
    s = sig_text(k);
    n = s.len();
    if (cnt < n) return 1'b0;
    if (s[n-1] != cur) return 1'b0;
    for (int j = 1; j < n; j++)
      if (s[n-1-j] != hist[j-1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic head_has(int at, string txt);
    for (int i = 0; i < 4; i++)
      if (head[at+i] != txt[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic format_passes(logic [7:0] cur, logic [31:0] cnt);
    case (ctype)
      CT_JPEG: begin
        if (cnt < 4) return 1'b0;
        if (head[0] != 8'hFF || head[1] != 8'hD8 || head[2] != 8'hFF) return 1'b0;
        return hist[0] == 8'hFF && cur == 8'hD9;
      end
      CT_PNG: begin
        if (cnt < 8) return 1'b0;
        for (int i = 0; i < 8; i++)
          if (head[i] != PNG_SIG[63-8*i -: 8]) return 1'b0;
        return 1'b1;
      end
      CT_WEBP: begin
        if (cnt < 12) return 1'b0;
        return head_has(0, "RIFF") && head_has(8, "WEBP");
      end
      CT_HEIF: begin
        if (cnt < 16) return 1'b0;
        if (!head_has(4, "ftyp")) return 1'b0;
        return head_has(8, "heic") || head_has(8, "heix") || head_has(8, "hevc") ||
               head_has(8, "hevx") || head_has(8, "mif1");
      end
      default: return 1'b1;
    endcase
  endfunction

  task automatic clear_buffer();
    for (int j = 0; j < 13; j++) hist[j] = 8'h00;
    seen = '0;
    hit_flag = 1'b0;
  endtask

  task automatic take_byte(logic [7:0] cur, logic is_last);
    logic [31:0] cnt;
    verdict_t    v;
    int          total;
    if (seen < HEAD_DEPTH) head[seen[3:0]] = cur;
    cnt = (seen == '1) ? seen : seen + 1;
    for (int k = 0; k < N_SIGS; k++)
      if (sig_ends_here(k, cur, cnt)) hit_flag = 1'b1;
    if (!is_last) begin
      for (int j = 12; j > 0; j--) hist[j] = hist[j-1];
      hist[0] = cur;
      seen = cnt;
    end else begin
      v.found = hit_flag;
      v.fmt_bad = !format_passes(cur, cnt);
      v.size_warn = cnt > limit;
      total = (v.found ? W_MATCH : 0) + (v.fmt_bad ? W_FORMAT : 0) +
              (v.size_warn ? W_SIZE : 0);
      v.risk = 4'((total > W_CAP) ? W_CAP : total);
      v.safe = !v.found && !v.fmt_bad;
      verdict_q.insert(verdict_q.size(), v);
      clear_buffer();
    end
  endtask

  task automatic check_verdict(verdict_t got);
    verdict_t want;
    logic     bad;
    if (verdict_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unrequested verdict %h at %0t", got, $realtime);
      return;
    end
    want = verdict_q.pop_front();
    bad = 1'b0;
    if (got.safe !== want.safe) bad = 1'b1;
    if (got.found !== want.found) bad = 1'b1;
    if (got.fmt_bad !== want.fmt_bad) bad = 1'b1;
    if (got.size_warn !== want.size_warn) bad = 1'b1;
    if (got.risk !== want.risk) bad = 1'b1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("verdict differs at %0t: safe %b/%b found %b/%b fmt_bad %b/%b %s %b/%b %s %0d/%0d",
                 $realtime, want.safe, got.safe, want.found, got.found, want.fmt_bad,
                 got.fmt_bad, "size_warn", want.size_warn, got.size_warn, "risk",
                 want.risk, got.risk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_buffer();
      ctype = CT_NONE;
      limit = LIMIT_AT_RESET;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CONTENT_TYPE: ctype = cfg_data[2:0];
          REG_SIZE_LIMIT:   limit = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_verdict(m_tdata);
    end
    outstanding <= verdict_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import css_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int ITEM_TARGET = 1850;
  localparam int SETTLE_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;   // data_byte
  logic             s_tlast = 1'b0;    // last_byte
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;           // is_safe, pattern_found, format_bad, size_warning, risk
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               mismatches;
  int               outstanding;

  bit               gaps_on = 1'b1;
  int               items_sent = 0;
  logic [7:0]       pkt [$];

  content_signature_scanner DUT (.*);
  scan_checker u_check (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // downstream stalls in random bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(0, 15);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic string sig_sample(int k);
    case (k)
      0:  return "\\x00";
      1:  return "\\x0a";
      2:  return "\\x0d";
      3:  return "<script";
      4:  return "</script>";
      5:  return "javascript:";
      6:  return "vbscript:";
      7:  return "data:text/html";
      8:  return "<?php";
      9:  return "<?=";
      10: return "<!--#";
      default: return "\\xff\\xd8\\xff";
    endcase
  endfunction

  function automatic string brand_sample(int k);
    case (k)
      0: return "heic";
      1: return "heix";
      2: return "hevc";
      3: return "hevx";
      4: return "mif1";
      default: return "avif";
    endcase
  endfunction

  task automatic send_byte(logic [7:0] d, logic l);
    int gap;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  // hold the input until every verdict is back, then let the pipeline drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_byte(logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic push_noise(int n);
    string alpha;
    alpha = "<>/?!-#=:scriptjavbdhml\\x0aFD";
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_byte(alpha[$urandom_range(0, alpha.len() - 1)]);
    end
  endtask

  // signature, sometimes cut short or with one byte changed
  task automatic push_sig();
    string s;
    int    n;
    s = sig_sample($urandom_range(0, 11));
    n = s.len();
    case ($urandom_range(0, 5))
      0: n = $urandom_range(1, n - 1);
      1: s[$urandom_range(0, n - 1)] = 8'($urandom_range(32, 126));
      default: ;
    endcase
    for (int i = 0; i < n; i++) add_byte(s[i]);
  endtask

  task automatic push_header(logic [2:0] kind);
    case (kind)
      CT_JPEG: begin
        add_byte(8'hFF);
        add_byte(8'hD8);
        add_byte(8'hFF);
      end
      CT_PNG: begin
        add_byte(8'h89);
        push_str("PNG");
        add_byte(8'h0D);
        add_byte(8'h0A);
        add_byte(8'h1A);
        add_byte(8'h0A);
      end
      CT_WEBP: begin
        push_str("RIFF");
        push_noise(4);
        push_str("WEBP");
      end
      CT_HEIF: begin
        push_noise(4);
        push_str("ftyp");
        push_str(brand_sample($urandom_range(0, 5)));
        push_noise(4);
      end
      default: ;
    endcase
  endtask

  task automatic build_buffer(logic [2:0] ct);
    int r;
    int body;
    int pos;
    r = $urandom_range(0, 9);
    if (r < 7) push_header(ct);
    else if (r < 9) push_header(3'($urandom_range(1, 4)));
    body = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
    while (body > 0) begin
      if ($urandom_range(0, 5) == 0) push_sig();
      else push_noise(1);
      body--;
    end
    if (ct == CT_JPEG && $urandom_range(0, 9) < 7) begin
      add_byte(8'hFF);
      add_byte(8'hD9);
    end
    // short buffers: a format check that runs out of bytes
    if ($urandom_range(0, 9) == 0 && pkt.size() > 1) begin
      pos = $urandom_range(1, pkt.size() - 1);
      pkt = pkt[0:pos-1];
    end
    if (pkt.size() == 0) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0) begin
      pos = $urandom_range(0, (pkt.size() > 16) ? 15 : pkt.size() - 1);
      pkt[pos][$urandom_range(0, 7)] = ~pkt[pos][$urandom_range(0, 7)];
    end
  endtask

  initial begin
    logic [2:0]  ct;
    logic [31:0] val;
    int          phase_no;
    int          phase_end;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and the match cases under the reset configuration
    add_byte(8'h00);
    send_pkt();
    add_byte(8'hFF);
    send_pkt();
    push_str("<?=");
    send_pkt();
    push_str("\\x0a");
    send_pkt();

    settle();
    write_reg(REG_CONTENT_TYPE, CFG_W'(CT_JPEG));
    write_reg(REG_SIZE_LIMIT, 32'd3);
    pkt = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
    send_pkt();
    push_str("<?=");
    send_pkt();
    pkt = '{8'hFF, 8'hD9};
    send_pkt();

    // unknown content type, size limit at zero, writes to unused indexes
    settle();
    write_reg(REG_CONTENT_TYPE, 32'hFFFF_FFFF);
    write_reg(REG_SIZE_LIMIT, 32'd0);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0002);
    add_byte(8'h0D);
    send_pkt();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      if (items_sent > ITEM_TARGET - 300) gaps_on = 1'b0;
      else gaps_on = ($urandom_range(0, 3) != 0);
      ct = 3'(phase_no % 8);
      val = $urandom;
      val[2:0] = ct;
      write_reg(REG_CONTENT_TYPE, val);
      case ($urandom_range(0, 4))
        0: val = 32'd0;
        1: val = 32'hFFFF_FFFF;
        2: val = $urandom_range(1, 30);
        3: val = 32'd52428800;
        default: val = $urandom;
      endcase
      write_reg(REG_SIZE_LIMIT, val);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      phase_end = items_sent + $urandom_range(60, 160);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        build_buffer(ct);
        send_pkt();
      end
      phase_no++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
